// ----- rtl/core/mk_pkg.sv -----
// Morse keyer package: widths, register indexes, control structs and the
// character decode and International Morse code table.
// No dependencies.
package mk_pkg;

   localparam int TABLE_ENTRIES = 36;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CHAR_W        = 8;
   localparam int DUR_W         = 16;
   localparam int MAX_SYMS      = 5;
   localparam int LEN_W         = $clog2(MAX_SYMS + 1);
   localparam int SEG_W         = $clog2(2 * MAX_SYMS + 1);
   localparam int CSR_IDX_W     = 3;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_DOT        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_GAP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_GAP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_GAP   = 3'd4;

   // Register reset values
   localparam logic [DUR_W-1:0] DOT_RESET        = 16'd100;
   localparam logic [DUR_W-1:0] DASH_RESET       = 16'd300;
   localparam logic [DUR_W-1:0] SYMBOL_GAP_RESET = 16'd100;
   localparam logic [DUR_W-1:0] LETTER_GAP_RESET = 16'd300;
   localparam logic [DUR_W-1:0] WORD_GAP_RESET   = 16'd700;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [IDX_W-1:0]  DIGIT_BASE   = 6'd26;

   // Morse code of one character: bit i of pattern is 1 for a dash at symbol i
   typedef struct packed {
      logic [LEN_W-1:0]    len;
      logic [MAX_SYMS-1:0] pattern;
   } mk_code_type;

   // Decoded input word
   typedef struct packed {
      logic        supported;
      logic        space;
      mk_code_type code;
   } mk_decode_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
   } mk_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic supported;
      logic final_seg;
   } mk_status_type;

   function automatic logic [DUR_W-1:0] sub_floor(input logic [DUR_W-1:0] a,
                                                  input logic [DUR_W-1:0] b);
      sub_floor = (a > b) ? (a - b) : '0;
   endfunction

   // International Morse code table, letters A to Z then digits 0 to 9
   function automatic mk_code_type code_lookup(input logic [IDX_W-1:0] idx);
      mk_code_type c;
      case (idx)
         6'd0:    c = '{len: 3'd2, pattern: 5'b00010}; // A
         6'd1:    c = '{len: 3'd4, pattern: 5'b00001}; // B
         6'd2:    c = '{len: 3'd4, pattern: 5'b00101}; // C
         6'd3:    c = '{len: 3'd3, pattern: 5'b00001}; // D
         6'd4:    c = '{len: 3'd1, pattern: 5'b00000}; // E
         6'd5:    c = '{len: 3'd4, pattern: 5'b00100}; // F
         6'd6:    c = '{len: 3'd3, pattern: 5'b00011}; // G
         6'd7:    c = '{len: 3'd4, pattern: 5'b00000}; // H
         6'd8:    c = '{len: 3'd2, pattern: 5'b00000}; // I
         6'd9:    c = '{len: 3'd4, pattern: 5'b01110}; // J
         6'd10:   c = '{len: 3'd3, pattern: 5'b00101}; // K
         6'd11:   c = '{len: 3'd4, pattern: 5'b00010}; // L
         6'd12:   c = '{len: 3'd2, pattern: 5'b00011}; // M
         6'd13:   c = '{len: 3'd2, pattern: 5'b00001}; // N
         6'd14:   c = '{len: 3'd3, pattern: 5'b00111}; // O
         6'd15:   c = '{len: 3'd4, pattern: 5'b00110}; // P
         6'd16:   c = '{len: 3'd4, pattern: 5'b01011}; // Q
         6'd17:   c = '{len: 3'd3, pattern: 5'b00010}; // R
         6'd18:   c = '{len: 3'd3, pattern: 5'b00000}; // S
         6'd19:   c = '{len: 3'd1, pattern: 5'b00001}; // T
         6'd20:   c = '{len: 3'd3, pattern: 5'b00100}; // U
         6'd21:   c = '{len: 3'd4, pattern: 5'b01000}; // V
         6'd22:   c = '{len: 3'd3, pattern: 5'b00110}; // W
         6'd23:   c = '{len: 3'd4, pattern: 5'b01001}; // X
         6'd24:   c = '{len: 3'd4, pattern: 5'b01101}; // Y
         6'd25:   c = '{len: 3'd4, pattern: 5'b00011}; // Z
         6'd26:   c = '{len: 3'd5, pattern: 5'b11111}; // 0
         6'd27:   c = '{len: 3'd5, pattern: 5'b11110}; // 1
         6'd28:   c = '{len: 3'd5, pattern: 5'b11100}; // 2
         6'd29:   c = '{len: 3'd5, pattern: 5'b11000}; // 3
         6'd30:   c = '{len: 3'd5, pattern: 5'b10000}; // 4
         6'd31:   c = '{len: 3'd5, pattern: 5'b00000}; // 5
         6'd32:   c = '{len: 3'd5, pattern: 5'b00001}; // 6
         6'd33:   c = '{len: 3'd5, pattern: 5'b00011}; // 7
         6'd34:   c = '{len: 3'd5, pattern: 5'b00111}; // 8
         6'd35:   c = '{len: 3'd5, pattern: 5'b01111}; // 9
         default: c = '{len: '0, pattern: '0};
      endcase
      code_lookup = c;
   endfunction

   // Fold case, classify the byte and fetch its code
   function automatic mk_decode_type char_decode(input logic [CHAR_W-1:0] ch);
      mk_decode_type d;
      logic [CHAR_W-1:0] diff;
      d    = '0;
      diff = '0;
      if (ch == CHAR_SPACE) begin
         d.supported = 1'b1;
         d.space     = 1'b1;
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         diff        = ch - CHAR_LOWER_A;
         d.supported = 1'b1;
         d.code      = code_lookup(diff[IDX_W-1:0]);
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         diff        = ch - CHAR_UPPER_A;
         d.supported = 1'b1;
         d.code      = code_lookup(diff[IDX_W-1:0]);
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         diff        = ch - CHAR_ZERO;
         d.supported = 1'b1;
         d.code      = code_lookup(diff[IDX_W-1:0] + DIGIT_BASE);
      end
      char_decode = d;
   endfunction

endpackage

// ----- rtl/core/mk_if.sv -----
// Valid/ready channel interfaces of the Morse keyer: text bytes in,
// key segments out. Depends on mk_pkg.
interface mk_req_if;
   logic                      valid;
   logic                      ready;
   logic [mk_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface mk_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     key_on;
   logic [mk_pkg::DUR_W-1:0] duration_ms;
   logic                     last;

   modport source (output valid, output key_on, output duration_ms, output last,
                   input ready);
   modport sink   (input valid, input key_on, input duration_ms, input last,
                   output ready);
endinterface

// ----- rtl/core/morse_keyer.sv -----
// Morse keyer top level: joins the controller and the datapath to the
// request, response and register ports. Depends on mk_pkg, mk_if, mk_ctrl, mk_dp.
//
// Each request word is one text byte; letters of either case and digits come
// out as International Morse key segments, a space as a single word gap, and
// any other byte is taken and dropped with no response. A character with n
// symbols gives 2n+1 response words (at most 11): mark, symbol gap per symbol,
// then the letter gap minus the symbol gap, floored at zero, with last set.
// A word is taken when the block is idle; the segments then leave one per cycle
// from a single output register while rsp_bus.ready is high. Registers
// (dot, dash, symbol gap, letter gap, word gap, in ms) are written on csr_wen
// and should only be changed while the block is idle.
module morse_keyer (
   input  logic                         clock,
   input  logic                         reset,
   mk_req_if.sink                       req_bus,
   mk_rsp_if.source                     rsp_bus,
   input  logic                         csr_wen,
   input  logic [mk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mk_pkg::DUR_W-1:0]     csr_wdata
);

   mk_pkg::mk_cmd_type    cmd;
   mk_pkg::mk_status_type status;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  key_on;
   logic [mk_pkg::DUR_W-1:0] duration_ms;
   logic                  last;

   mk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mk_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .char_code   (req_bus.char_code),
      .cmd         (cmd),
      .status      (status),
      .key_on      (key_on),
      .duration_ms (duration_ms),
      .last        (last)
   );

   // Drive the channels
   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.key_on      = key_on;
   assign rsp_bus.duration_ms = duration_ms;
   assign rsp_bus.last        = last;

endmodule

// ----- rtl/core/mk_ctrl.sv -----
// Morse keyer controller: takes a word when idle, then walks the segments
// of the character out one handshake at a time. Depends on mk_pkg.
module mk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mk_pkg::mk_status_type status,
   output mk_pkg::mk_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } mk_state_type;

   mk_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && status.supported) begin
               cmd.load = 1'b1;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.final_seg) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/mk_dp.sv -----
// Morse keyer datapath: timing registers, the latched code of the current
// character, the segment counter and the output segment register.
// Depends on mk_pkg.
module mk_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [mk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mk_pkg::DUR_W-1:0]     csr_wdata,
   input  logic [mk_pkg::CHAR_W-1:0]    char_code,
   input  mk_pkg::mk_cmd_type           cmd,
   output mk_pkg::mk_status_type        status,
   output logic                         key_on,
   output logic [mk_pkg::DUR_W-1:0]     duration_ms,
   output logic                         last
);

   logic [mk_pkg::DUR_W-1:0] dot_ff, dash_ff, symbol_gap_ff, letter_gap_ff, word_gap_ff;

   logic [mk_pkg::MAX_SYMS-1:0] pattern_ff, pattern_in;
   logic [mk_pkg::SEG_W-1:0]    seg_ff, seg_in;
   logic [mk_pkg::SEG_W-1:0]    final_ff, final_in;
   logic                        space_ff, space_in;

   logic                     key_on_ff, key_on_in;
   logic [mk_pkg::DUR_W-1:0] dur_ff, dur_in;
   logic                     last_ff, last_in;

   mk_pkg::mk_decode_type dec;
   logic                  seg_final;

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff        <= mk_pkg::DOT_RESET;
         dash_ff       <= mk_pkg::DASH_RESET;
         symbol_gap_ff <= mk_pkg::SYMBOL_GAP_RESET;
         letter_gap_ff <= mk_pkg::LETTER_GAP_RESET;
         word_gap_ff   <= mk_pkg::WORD_GAP_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            mk_pkg::CSR_DOT:        dot_ff        <= csr_wdata;
            mk_pkg::CSR_DASH:       dash_ff       <= csr_wdata;
            mk_pkg::CSR_SYMBOL_GAP: symbol_gap_ff <= csr_wdata;
            mk_pkg::CSR_LETTER_GAP: letter_gap_ff <= csr_wdata;
            mk_pkg::CSR_WORD_GAP:   word_gap_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Decode the incoming word
   assign dec = mk_pkg::char_decode(char_code);

   // Select the character being sent and the next segment number
   always_comb begin
      if (cmd.load) begin
         pattern_in = dec.code.pattern;
         space_in   = dec.space;
         final_in   = dec.space ? '0 : {dec.code.len, 1'b0};
         seg_in     = '0;
      end else begin
         pattern_in = pattern_ff;
         space_in   = space_ff;
         final_in   = final_ff;
         seg_in     = cmd.advance ? seg_ff + 1'b1 : seg_ff;
      end
   end

   // Build the next segment: mark on even numbers, symbol gap on odd,
   // letter or word gap at the end
   always_comb begin
      seg_final = (seg_in == final_in);
      last_in   = seg_final;
      key_on_in = !seg_final && !seg_in[0];
      if (seg_final) begin
         dur_in = space_in ? mk_pkg::sub_floor(word_gap_ff, letter_gap_ff)
                           : mk_pkg::sub_floor(letter_gap_ff, symbol_gap_ff);
      end else if (seg_in[0]) begin
         dur_in = symbol_gap_ff;
      end else begin
         dur_in = pattern_in[seg_in[mk_pkg::SEG_W-1:1]] ? dash_ff : dot_ff;
      end
   end

   // Hold the character state
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else begin
         seg_ff <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
      space_ff   <= space_in;
      final_ff   <= final_in;
   end

   // Load the output segment register
   always_ff @(posedge clock) begin
      if (cmd.load || cmd.advance) begin
         key_on_ff <= key_on_in;
         dur_ff    <= dur_in;
         last_ff   <= last_in;
      end
   end

   assign key_on           = key_on_ff;
   assign duration_ms      = dur_ff;
   assign last             = last_ff;
   assign status.supported = dec.supported;
   assign status.final_seg = last_ff;

endmodule

// ----- rtl/core/mk_checker.sv -----
// Port-level checks for the Morse keyer, bound to the top level.
// Depends on mk_pkg and morse_keyer.
module mk_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_key_on,
   input logic [mk_pkg::DUR_W-1:0] rsp_duration_ms,
   input logic                     rsp_last
);

   // Stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_key_on) && $stable(rsp_duration_ms)
         && $stable(rsp_last))
      else $error("stalled response word changed");

   // No new request while a segment is pending
   a_one_char: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while response pending");

   // A mark is never the final segment of a character
   a_mark_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_on |-> !rsp_last)
      else $error("mark flagged as last");

   // A mark is followed at once by a gap
   a_gap_after_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_key_on |=> rsp_valid && !rsp_key_on)
      else $error("no gap after mark");

   // After the last segment the block is idle again
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("not idle after last segment");

endmodule

bind morse_keyer mk_checker u_mk_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_key_on      (rsp_bus.key_on),
   .rsp_duration_ms (rsp_bus.duration_ms),
   .rsp_last        (rsp_bus.last)
);

// ----- dv/morse_keyer_tb.sv -----
// Self-checking testbench of the Morse keyer: drives text bytes and register
// writes, predicts every key segment and compares each response word.
// Depends on mk_pkg, mk_if and morse_keyer.
`timescale 1ns / 100ps

module morse_keyer_tb;

   // One key segment as it leaves the block
   typedef struct packed {
      logic                     key_on;
      logic [mk_pkg::DUR_W-1:0] duration_ms;
      logic                     last;
   } key_seg_type;

   // One row of text stimulus; typed rows carry their segments spelled out
   typedef struct packed {
      logic [mk_pkg::CHAR_W-1:0] ch;
      logic                      typed;
      logic [1:0]                n;
      key_seg_type [0:2]         segs;
   } text_row_type;

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 16;
   localparam int END_CYCLES       = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 25;
   localparam int LETTER_COUNT     = 26;

   // Indexes beyond the register file; writes there must be ignored
   localparam logic [mk_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [mk_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam byte DAH = "-";

   localparam key_seg_type [0:2] NO_SEGS = '0;

   // Directed text, all sent with the reset register values
   localparam text_row_type DIRECTED_TEXT [22] = '{
      '{"E",   1'b1, 2'd3, '{'{1'b1, 16'd100, 1'b0}, '{1'b0, 16'd100, 1'b0},
                             '{1'b0, 16'd200, 1'b1}}},
      '{"T",   1'b1, 2'd3, '{'{1'b1, 16'd300, 1'b0}, '{1'b0, 16'd100, 1'b0},
                             '{1'b0, 16'd200, 1'b1}}},
      '{" ",   1'b1, 2'd1, '{'{1'b0, 16'd400, 1'b1}, key_seg_type'('0),
                             key_seg_type'('0)}},
      '{8'h00, 1'b1, 2'd0, NO_SEGS},
      '{8'hFF, 1'b1, 2'd0, NO_SEGS},
      '{8'h40, 1'b1, 2'd0, NO_SEGS},
      '{8'h5B, 1'b1, 2'd0, NO_SEGS},
      '{8'h60, 1'b1, 2'd0, NO_SEGS},
      '{8'h7B, 1'b1, 2'd0, NO_SEGS},
      '{8'h2F, 1'b1, 2'd0, NO_SEGS},
      '{8'h3A, 1'b1, 2'd0, NO_SEGS},
      '{8'h1F, 1'b1, 2'd0, NO_SEGS},
      '{8'hC5, 1'b1, 2'd0, NO_SEGS},
      '{8'hA0, 1'b1, 2'd0, NO_SEGS},
      '{"A",   1'b0, 2'd0, NO_SEGS},
      '{"Z",   1'b0, 2'd0, NO_SEGS},
      '{"a",   1'b0, 2'd0, NO_SEGS},
      '{"z",   1'b0, 2'd0, NO_SEGS},
      '{"0",   1'b0, 2'd0, NO_SEGS},
      '{"9",   1'b0, 2'd0, NO_SEGS},
      '{"5",   1'b0, 2'd0, NO_SEGS},
      '{"Q",   1'b0, 2'd0, NO_SEGS}
   };

   // International Morse code, letters A to Z then digits 0 to 9
   string code_book [mk_pkg::TABLE_ENTRIES] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-",
      ".....", "-....", "--...", "---..", "----."
   };

   logic                         clock;
   logic                         reset;
   logic                         csr_wen;
   logic [mk_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mk_pkg::DUR_W-1:0]     csr_wdata;

   mk_req_if req_bus ();
   mk_rsp_if rsp_bus ();

   // Shadow copy of the timing registers
   logic [mk_pkg::DUR_W-1:0] dot_len;
   logic [mk_pkg::DUR_W-1:0] dash_len;
   logic [mk_pkg::DUR_W-1:0] sym_gap;
   logic [mk_pkg::DUR_W-1:0] letter_gap;
   logic [mk_pkg::DUR_W-1:0] word_gap;

   key_seg_type pending_segments [$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   logic        hold_req       = 1'b0;

   morse_keyer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Map a byte to its code table row, folding lower case; -1 if not keyed
   function automatic int char_index(input logic [mk_pkg::CHAR_W-1:0] ch);
      if (ch >= mk_pkg::CHAR_LOWER_A && ch <= mk_pkg::CHAR_LOWER_Z) begin
         return int'(ch - mk_pkg::CHAR_LOWER_A);
      end
      if (ch >= mk_pkg::CHAR_UPPER_A && ch <= mk_pkg::CHAR_UPPER_Z) begin
         return int'(ch - mk_pkg::CHAR_UPPER_A);
      end
      if (ch >= mk_pkg::CHAR_ZERO && ch <= mk_pkg::CHAR_NINE) begin
         return int'(ch - mk_pkg::CHAR_ZERO) + LETTER_COUNT;
      end
      return -1;
   endfunction

   // Queue the key segments that one text byte should produce
   function automatic void predict_segments(input logic [mk_pkg::CHAR_W-1:0] ch);
      int          idx;
      string       code;
      key_seg_type seg;
      idx = char_index(ch);
      if (ch == mk_pkg::CHAR_SPACE) begin
         seg.key_on      = 1'b0;
         seg.duration_ms = (word_gap > letter_gap) ? word_gap - letter_gap : '0;
         seg.last        = 1'b1;
         pending_segments.push_back(seg);
         return;
      end
      if (idx < 0) return;
      code = code_book[idx];
      for (int k = 0; k < code.len(); k++) begin
         seg.key_on      = 1'b1;
         seg.duration_ms = (code[k] == DAH) ? dash_len : dot_len;
         seg.last        = 1'b0;
         pending_segments.push_back(seg);
         seg.key_on      = 1'b0;
         seg.duration_ms = sym_gap;
         pending_segments.push_back(seg);
      end
      seg.key_on      = 1'b0;
      seg.duration_ms = (letter_gap > sym_gap) ? letter_gap - sym_gap : '0;
      seg.last        = 1'b1;
      pending_segments.push_back(seg);
   endfunction

   // Mostly keyed text with random content, the rest any byte at all
   function automatic logic [mk_pkg::CHAR_W-1:0] pick_char();
      int r;
      int s;
      r = $urandom_range(99);
      s = $urandom_range(61);
      if (r < 25) return mk_pkg::CHAR_W'($urandom_range(255));
      if (r < 33) return mk_pkg::CHAR_SPACE;
      if (s < 26) return mk_pkg::CHAR_UPPER_A + mk_pkg::CHAR_W'(s);
      if (s < 52) return mk_pkg::CHAR_LOWER_A + mk_pkg::CHAR_W'(s - 26);
      return mk_pkg::CHAR_ZERO + mk_pkg::CHAR_W'(s - 52);
   endfunction

   // Mostly short durations, now and then anything in range
   function automatic logic [mk_pkg::DUR_W-1:0] draw_ms(input int floor_ms);
      if ($urandom_range(3) == 0) return mk_pkg::DUR_W'($urandom_range(65535, floor_ms));
      return mk_pkg::DUR_W'($urandom_range(1000, floor_ms));
   endfunction

   // Put one register write on the port; caller lowers the enable afterwards
   task automatic csr_put(input logic [mk_pkg::CSR_IDX_W-1:0] idx,
                          input logic [mk_pkg::DUR_W-1:0]     val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         mk_pkg::CSR_DOT:        dot_len    = val;
         mk_pkg::CSR_DASH:       dash_len   = val;
         mk_pkg::CSR_SYMBOL_GAP: sym_gap    = val;
         mk_pkg::CSR_LETTER_GAP: letter_gap = val;
         mk_pkg::CSR_WORD_GAP:   word_gap   = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Load the timing set of one phase: extremes first, then random sets
   task automatic program_phase(input int p);
      case (p)
         0: begin
            csr_put(mk_pkg::CSR_DOT, 16'd1);
            csr_put(mk_pkg::CSR_DASH, 16'd1);
            csr_put(mk_pkg::CSR_SYMBOL_GAP, 16'd0);
            csr_put(mk_pkg::CSR_LETTER_GAP, 16'd0);
            csr_put(mk_pkg::CSR_WORD_GAP, 16'd0);
         end
         1: begin
            csr_put(mk_pkg::CSR_DOT, 16'hFFFF);
            csr_put(mk_pkg::CSR_DASH, 16'hFFFF);
            csr_put(mk_pkg::CSR_SYMBOL_GAP, 16'hFFFF);
            csr_put(mk_pkg::CSR_LETTER_GAP, 16'hFFFF);
            csr_put(mk_pkg::CSR_WORD_GAP, 16'hFFFF);
         end
         2: begin
            // letter gap below symbol gap floors to zero
            csr_put(mk_pkg::CSR_DOT, draw_ms(1));
            csr_put(mk_pkg::CSR_DASH, draw_ms(1));
            csr_put(mk_pkg::CSR_SYMBOL_GAP, 16'hFFFF);
            csr_put(mk_pkg::CSR_LETTER_GAP, 16'd0);
            csr_put(mk_pkg::CSR_WORD_GAP, 16'hFFFF);
            csr_put(CSR_SPARE_LO, 16'hFFFF);
            csr_put(CSR_SPARE_HI, 16'h0001);
         end
         3: begin
            // word gap below letter gap floors to zero
            csr_put(mk_pkg::CSR_DOT, 16'hFFFF);
            csr_put(mk_pkg::CSR_DASH, 16'd1);
            csr_put(mk_pkg::CSR_SYMBOL_GAP, 16'd0);
            csr_put(mk_pkg::CSR_LETTER_GAP, 16'hFFFF);
            csr_put(mk_pkg::CSR_WORD_GAP, 16'd0);
         end
         default: begin
            csr_put(mk_pkg::CSR_DOT, draw_ms(1));
            csr_put(mk_pkg::CSR_DASH, draw_ms(1));
            csr_put(mk_pkg::CSR_SYMBOL_GAP, draw_ms(0));
            csr_put(mk_pkg::CSR_LETTER_GAP, draw_ms(0));
            csr_put(mk_pkg::CSR_WORD_GAP, draw_ms(0));
         end
      endcase
      csr_wen <= 1'b0;
   endtask

   // Offer one byte after a random gap, hold it until taken, then predict
   task automatic offer_char(input text_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= row.ch;
      do @(posedge clock); while (!req_bus.ready);
      if (row.typed) begin
         for (int k = 0; k < row.n; k++) pending_segments.push_back(row.segs[k]);
      end else begin
         predict_segments(row.ch);
      end
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted segment has left the block
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_segments.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_req) begin
            hold_req      = 1'b0;
            hold_left     = LONG_HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Compare every accepted response word with the oldest prediction
   always @(posedge clock) begin
      key_seg_type got;
      key_seg_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.key_on, rsp_bus.duration_ms, rsp_bus.last};
         if (pending_segments.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected segment key_on=%0b duration_ms=%0d last=%0b",
                     $time, got.key_on, got.duration_ms, got.last);
         end else begin
            want = pending_segments.pop_front();
            if (got.key_on !== want.key_on || got.duration_ms !== want.duration_ms ||
                got.last !== want.last) begin
               mismatch_count++;
               $display("%0t: segment mismatch expected key_on=%0b duration_ms=%0d last=%0b",
                        $time, want.key_on, want.duration_ms, want.last);
               $display("%0t:                  actual   key_on=%0b duration_ms=%0d last=%0b",
                        $time, got.key_on, got.duration_ms, got.last);
            end
         end
      end
   end

   // Stimulus: reset, directed text, then random text over several timing sets
   initial begin
      int                        taken;
      logic [mk_pkg::CHAR_W-1:0] ch;
      text_row_type              row;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      csr_wen           = 1'b0;
      csr_index         = mk_pkg::CSR_DOT;
      csr_wdata         = '0;
      dot_len           = mk_pkg::DOT_RESET;
      dash_len          = mk_pkg::DASH_RESET;
      sym_gap           = mk_pkg::SYMBOL_GAP_RESET;
      letter_gap        = mk_pkg::LETTER_GAP_RESET;
      word_gap          = mk_pkg::WORD_GAP_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_TEXT[i]) offer_char(DIRECTED_TEXT[i]);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         program_phase(p);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         // back up the block while text keeps coming
         if (p == 0) hold_req = 1'b1;
         taken = 0;
         while (taken < ITEMS_PER_PHASE) begin
            ch     = pick_char();
            row    = '0;
            row.ch = ch;
            offer_char(row);
            taken++;
         end
      end

      wait_idle();
      repeat (END_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/mk_pkg.sv
rtl/core/mk_if.sv
rtl/core/mk_ctrl.sv
rtl/core/mk_dp.sv
rtl/core/morse_keyer.sv
rtl/core/mk_checker.sv
dv/morse_keyer_tb.sv
